@@ rtl/assert_macros.svh @@
// Shared assertion shorthands for the checkers in this folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// Condition in one cycle implies a consequence in the next one.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fur_pkg.sv @@
package fur_pkg;

  typedef enum logic [3:0] {
    PhHunt,
    PhVersion,
    PhCommand,
    PhSkipCmd,
    PhLang,
    PhPlen0,
    PhPlen1,
    PhPath,
    PhDlen,
    PhData,
    PhCrc
  } fur_phase_e;

  typedef enum logic [2:0] {
    StOk          = 3'd0,
    StBadLang     = 3'd1,
    StBadPath     = 3'd2,
    StCrcMismatch = 3'd3,
    StTooLarge    = 3'd4
  } fur_status_e;

  typedef enum logic [1:0] {
    KindReply = 2'd0,
    KindPath  = 2'd1,
    KindData  = 2'd2
  } fur_kind_e;

  typedef enum logic [1:0] {
    CfgLang0  = 2'd0,
    CfgLang1  = 2'd1,
    CfgMaxLen = 2'd2
  } fur_cfg_e;

  typedef struct packed {
    fur_kind_e   kind;
    logic [7:0]  data;
    fur_status_e status;
    logic        last;
  } fur_result_t;

  // Up to two words produced by one received byte, in delivery order.
  typedef struct packed {
    logic [1:0]  count;
    fur_result_t first;
    fur_result_t second;
  } fur_emit_t;

  localparam int unsigned DefMaxPathLen = 220;
  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned QueuePtrW     = $clog2(QueueDepth);
  localparam int unsigned QueueCntW     = $clog2(QueueDepth + 1);

  localparam logic        DefLang0      = 1'b1;
  localparam logic        DefLang1      = 1'b0;
  localparam logic [31:0] DefMaxPayload = 32'd524288;

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  // Sync pattern, first byte in the lowest lane.
  localparam logic [3:0][7:0] MagicWord = {8'h54, 8'h41, 8'h4B, 8'h41};

  localparam logic [7:0] VersionOne = 8'h01;
  localparam logic [7:0] CmdPing    = 8'h01;
  localparam logic [7:0] CmdPut     = 8'h02;
  localparam logic [7:0] LangZero   = 8'h00;
  localparam logic [7:0] LangOne    = 8'h01;

  localparam logic [7:0] CharSpace     = 8'h20;
  localparam logic [7:0] CharDot       = 8'h2E;
  localparam logic [7:0] CharSlash     = 8'h2F;
  localparam logic [7:0] CharColon     = 8'h3A;
  localparam logic [7:0] CharBackslash = 8'h5C;

  // Reflected CRC-32 update for one byte.
  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

@@ rtl/framed_upload_receiver_top.sv @@
// Path: a byte is registered on acceptance and its words enter the output queue
//   when the parser takes it, which waits while the queue lacks room for a pair.
// Throughput: one byte per cycle while the sink keeps up; a rejected path's last byte
//   yields two words; input stalls while the four-word output queue holds over two.
// Reset (rst_ni low, asynchronous): parser hunts for the sync pattern, queue empty,
//   registers return to lang0 on, lang1 off, payload limit 524288.
module framed_upload_receiver_top import fur_pkg::*; #(
  parameter int unsigned MAX_PATH_LEN = DefMaxPathLen
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] reply_status
  output logic [1:0]  m_axis_tuser,   // [1:0] out_kind
  output logic        m_axis_tlast,   // is_last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic        lang0_q, lang1_q;
  logic [31:0] max_len_q;
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        space;
  logic        fire;
  fur_emit_t   emit;
  fur_result_t head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lang0_q   <= DefLang0;
      lang1_q   <= DefLang1;
      max_len_q <= DefMaxPayload;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgLang0:  lang0_q   <= cfg_data_i[0];
        CfgLang1:  lang1_q   <= cfg_data_i[0];
        CfgMaxLen: max_len_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  assign fire          = in_valid_q && space;
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  fur_parser #(
    .MAX_PATH_LEN(MAX_PATH_LEN)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .byte_i    (in_byte_q),
    .lang0_en_i(lang0_q),
    .lang1_en_i(lang1_q),
    .max_len_i (max_len_q),
    .emit_o    (emit)
  );

  fur_out_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fire),
    .emit_i (emit),
    .space_o(space),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .head_o (head)
  );

  assign m_axis_tdata = {5'b00000, head.status, head.data};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

@@ rtl/fur_parser.sv @@
module fur_parser import fur_pkg::*; #(
  parameter int unsigned MAX_PATH_LEN = DefMaxPathLen
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic [7:0]  byte_i,
  input  logic        lang0_en_i,
  input  logic        lang1_en_i,
  input  logic [31:0] max_len_i,
  output fur_emit_t   emit_o
);

  fur_phase_e  phase_q, phase_d;
  logic [1:0]  match_q, match_d;
  logic [31:0] cnt_q, cnt_d;
  logic [7:0]  lang_q, lang_d;
  logic [15:0] plen_q, plen_d;
  logic        rej_q, rej_d;
  logic [1:0]  dots_q, dots_d;
  logic [31:0] paylen_q, paylen_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] rcv_q, rcv_d;

  logic [31:0] cnt_inc;
  logic [31:0] lane_val;
  logic [15:0] plen_full;
  logic        rej_n;
  logic [1:0]  dots_n;
  logic        rej_f;
  logic        lang_ok;
  logic [31:0] paylen_next;
  logic [31:0] rcv_next;

  always_comb begin
    cnt_inc     = cnt_q + 32'd1;
    lane_val    = {24'h0, byte_i} << {cnt_q[1:0], 3'b000};
    plen_full   = {byte_i, plen_q[7:0]};
    paylen_next = paylen_q | lane_val;
    rcv_next    = rcv_q | lane_val;

    rej_n = rej_q;
    if ((cnt_q == 32'd0) && (byte_i == CharSlash || byte_i == CharBackslash)) begin
      rej_n = 1'b1;
    end
    if (byte_i < CharSpace || byte_i == CharBackslash || byte_i == CharColon) begin
      rej_n = 1'b1;
    end
    if (byte_i == CharSlash) begin
      if (dots_q == 2'd2) begin
        rej_n = 1'b1;
      end
      dots_n = 2'd0;
    end else if (byte_i == CharDot) begin
      dots_n = (dots_q == 2'd3) ? 2'd3 : dots_q + 2'd1;
    end else begin
      dots_n = 2'd3;
    end
    rej_f   = rej_n | (dots_n == 2'd2);
    lang_ok = (lang_q == LangZero && lang0_en_i) || (lang_q == LangOne && lang1_en_i);
  end

  always_comb begin
    phase_d  = phase_q;
    match_d  = match_q;
    cnt_d    = cnt_q;
    lang_d   = lang_q;
    plen_d   = plen_q;
    rej_d    = rej_q;
    dots_d   = dots_q;
    paylen_d = paylen_q;
    crc_d    = crc_q;
    rcv_d    = rcv_q;
    emit_o   = '0;

    unique case (phase_q)
      PhHunt: begin
        if (byte_i != MagicWord[match_q]) begin
          match_d = (byte_i == MagicWord[0]) ? 2'd1 : 2'd0;
        end else if (match_q == 2'd3) begin
          match_d = 2'd0;
          phase_d = PhVersion;
        end else begin
          match_d = match_q + 2'd1;
        end
      end
      PhVersion: begin
        phase_d = (byte_i == VersionOne) ? PhCommand : PhSkipCmd;
      end
      PhSkipCmd: begin
        phase_d = PhHunt;
        match_d = 2'd0;
        cnt_d   = '0;
      end
      PhCommand: begin
        if (byte_i == CmdPut) begin
          phase_d = PhLang;
        end else begin
          phase_d = PhHunt;
          match_d = 2'd0;
          cnt_d   = '0;
          if (byte_i == CmdPing) begin
            emit_o.count        = 2'd1;
            emit_o.first.kind   = KindReply;
            emit_o.first.status = StOk;
          end
        end
      end
      PhLang: begin
        lang_d  = byte_i;
        phase_d = PhPlen0;
      end
      PhPlen0: begin
        plen_d  = {8'h00, byte_i};
        phase_d = PhPlen1;
      end
      PhPlen1: begin
        plen_d = plen_full;
        if (plen_full == 16'd0 || plen_full >= 16'(MAX_PATH_LEN)) begin
          phase_d = PhHunt;
          match_d = 2'd0;
          cnt_d   = '0;
          emit_o.count        = 2'd1;
          emit_o.first.kind   = KindReply;
          emit_o.first.status = StBadPath;
        end else begin
          rej_d   = 1'b0;
          dots_d  = 2'd0;
          cnt_d   = '0;
          phase_d = PhPath;
        end
      end
      PhPath: begin
        rej_d  = rej_n;
        dots_d = dots_n;
        cnt_d  = cnt_inc;
        emit_o.count      = 2'd1;
        emit_o.first.kind = KindPath;
        emit_o.first.data = byte_i;
        if (cnt_inc == {16'h0, plen_q}) begin
          emit_o.first.last = 1'b1;
          rej_d = rej_f;
          if (rej_f || !lang_ok) begin
            phase_d = PhHunt;
            match_d = 2'd0;
            cnt_d   = '0;
            emit_o.count         = 2'd2;
            emit_o.second.kind   = KindReply;
            emit_o.second.status = rej_f ? StBadPath : StBadLang;
          end else begin
            cnt_d    = '0;
            paylen_d = '0;
            phase_d  = PhDlen;
          end
        end
      end
      PhDlen: begin
        paylen_d = paylen_next;
        cnt_d    = cnt_inc;
        if (cnt_q[1:0] == 2'd3) begin
          cnt_d = '0;
          if (paylen_next > max_len_i) begin
            phase_d = PhHunt;
            match_d = 2'd0;
            emit_o.count        = 2'd1;
            emit_o.first.kind   = KindReply;
            emit_o.first.status = StTooLarge;
          end else begin
            crc_d   = CrcInit;
            rcv_d   = '0;
            phase_d = (paylen_next == 32'd0) ? PhCrc : PhData;
          end
        end
      end
      PhData: begin
        crc_d = crc32_byte(crc_q, byte_i);
        cnt_d = cnt_inc;
        emit_o.count      = 2'd1;
        emit_o.first.kind = KindData;
        emit_o.first.data = byte_i;
        if (cnt_inc == paylen_q) begin
          emit_o.first.last = 1'b1;
          cnt_d   = '0;
          phase_d = PhCrc;
        end
      end
      PhCrc: begin
        rcv_d = rcv_next;
        cnt_d = cnt_inc;
        if (cnt_q[1:0] == 2'd3) begin
          phase_d = PhHunt;
          match_d = 2'd0;
          cnt_d   = '0;
          emit_o.count        = 2'd1;
          emit_o.first.kind   = KindReply;
          emit_o.first.status = ((~crc_q) == rcv_next) ? StOk : StCrcMismatch;
        end
      end
      default: begin
        phase_d = PhHunt;
        match_d = 2'd0;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHunt;
      match_q  <= 2'd0;
      cnt_q    <= '0;
      lang_q   <= '0;
      plen_q   <= '0;
      rej_q    <= 1'b0;
      dots_q   <= 2'd0;
      paylen_q <= '0;
      crc_q    <= CrcInit;
      rcv_q    <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      match_q  <= match_d;
      cnt_q    <= cnt_d;
      lang_q   <= lang_d;
      plen_q   <= plen_d;
      rej_q    <= rej_d;
      dots_q   <= dots_d;
      paylen_q <= paylen_d;
      crc_q    <= crc_d;
      rcv_q    <= rcv_d;
    end
  end

endmodule

@@ rtl/fur_out_queue.sv @@
module fur_out_queue import fur_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  fur_emit_t   emit_i,
  output logic        space_o,
  output logic        valid_o,
  input  logic        ready_i,
  output fur_result_t head_o
);

  fur_result_t          mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueueCntW-1:0] cnt_q;
  logic [1:0]           push_n;
  logic                 pop;

  assign push_n  = push_i ? emit_i.count : 2'd0;
  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  // Room for a full pair regardless of what drains this cycle.
  assign space_o = (cnt_q <= QueueCntW'(QueueDepth - 2));

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wr_q] <= emit_i.first;
    end
    if (push_n == 2'd2) begin
      mem_q[wr_q + QueuePtrW'(1)] <= emit_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QueuePtrW'(push_n);
      rd_q  <= rd_q + QueuePtrW'(pop);
      cnt_q <= cnt_q + QueueCntW'(push_n) - QueueCntW'(pop);
    end
  end

endmodule

@@ rtl/fur_checker.sv @@
`include "assert_macros.svh"

module fur_checker import fur_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // Replies carry a status only: no byte, no end mark, a known code.
  `ASSERT_ALWAYS(a_reply_clean, clk_i, rst_ni, !m_axis_tvalid || m_axis_tuser != KindReply || (m_axis_tdata[7:0] == 8'h00 && !m_axis_tlast && m_axis_tdata[10:8] <= StTooLarge), "reply word carries byte, end mark or bad status")

  // Forwarded bytes are path or payload and carry no status.
  `ASSERT_ALWAYS(a_fwd_clean, clk_i, rst_ni, !m_axis_tvalid || m_axis_tuser == KindReply || ((m_axis_tuser == KindPath || m_axis_tuser == KindData) && m_axis_tdata[10:8] == StOk), "forwarded word has bad kind or nonzero status")

  // Hold the word while the sink stalls.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output word changed while stalled")

endmodule

bind framed_upload_receiver_top fur_checker u_fur_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

@@ bench/tb_framed_upload_receiver_top.sv @@
`timescale 1ns / 1ps

module tb_framed_upload_receiver_top;
  import fur_pkg::*;

  localparam int unsigned PathLimit    = DefMaxPathLen;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned QuietLimit   = 5000;
  localparam logic [1:0]  CfgUnused    = 2'd3;

  typedef struct packed {
    logic [1:0]  idx;
    logic [31:0] val;
  } reg_write_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = 2'd0;
  logic [31:0] cfg_data_i = 32'h0;

  framed_upload_receiver_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  logic [7:0]  link_bytes[$];
  logic [7:0]  path_buf[$];
  reg_write_t  cfg_writes[$];
  fur_result_t due_words[$];

  int unsigned send_gap_pct = 0;
  int unsigned stall_pct    = 0;
  int unsigned sent_count   = 0;
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;

  // Parser shadow state and register copies
  fur_phase_e  ph          = PhHunt;
  logic [1:0]  sync_hits   = 2'd0;
  logic [31:0] field_cnt   = 32'h0;
  logic [7:0]  lang_sel    = 8'h00;
  logic [15:0] name_len    = 16'h0;
  logic        path_bad    = 1'b0;
  logic [1:0]  dot_run     = 2'd0;
  logic [31:0] body_len    = 32'h0;
  logic [31:0] crc_acc     = CrcInit;
  logic [31:0] crc_rx      = 32'h0;
  logic        lang0_on    = DefLang0;
  logic        lang1_on    = DefLang1;
  logic [31:0] payload_cap = DefMaxPayload;

  function automatic logic [31:0] crc_fold(logic [31:0] acc, logic [7:0] b);
    logic [31:0] r;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      if (r[0] ^ b[k]) r = (r >> 1) ^ CrcPoly;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic void push_word(fur_kind_e k, logic [7:0] d, fur_status_e s, logic l);
    fur_result_t w;
    w.kind   = k;
    w.data   = d;
    w.status = s;
    w.last   = l;
    due_words.push_back(w);
  endfunction

  function automatic void rehunt();
    ph        = PhHunt;
    sync_hits = 2'd0;
    field_cnt = 32'h0;
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      CfgLang0:  lang0_on = val[0];
      CfgLang1:  lang1_on = val[0];
      CfgMaxLen: payload_cap = val;
      default: ;
    endcase
  endfunction

  // Advance the shadow parser by one link byte and queue the words it yields.
  function automatic void take_byte(logic [7:0] b);
    logic lang_ok;
    logic fin;
    case (ph)
      PhHunt: begin
        if (b != MagicWord[sync_hits]) begin
          sync_hits = (b == MagicWord[0]) ? 2'd1 : 2'd0;
        end else if (sync_hits == 2'd3) begin
          sync_hits = 2'd0;
          ph = PhVersion;
        end else begin
          sync_hits++;
        end
      end
      PhVersion: ph = (b == VersionOne) ? PhCommand : PhSkipCmd;
      PhSkipCmd: rehunt();
      PhCommand: begin
        if (b == CmdPing) begin
          rehunt();
          push_word(KindReply, 8'h00, StOk, 1'b0);
        end else if (b == CmdPut) begin
          ph = PhLang;
        end else begin
          rehunt();
        end
      end
      PhLang: begin
        lang_sel = b;
        ph = PhPlen0;
      end
      PhPlen0: begin
        name_len = {8'h00, b};
        ph = PhPlen1;
      end
      PhPlen1: begin
        name_len[15:8] = b;
        if (name_len == 16'h0 || name_len >= PathLimit) begin
          rehunt();
          push_word(KindReply, 8'h00, StBadPath, 1'b0);
        end else begin
          path_bad  = 1'b0;
          dot_run   = 2'd0;
          field_cnt = 32'h0;
          ph = PhPath;
        end
      end
      PhPath: begin
        if (field_cnt == 0 && (b == CharSlash || b == CharBackslash)) path_bad = 1'b1;
        if (b < CharSpace || b == CharBackslash || b == CharColon) path_bad = 1'b1;
        // dot_run saturates at 3 once the component holds anything but dots, or three dots
        if (b == CharSlash) begin
          if (dot_run == 2'd2) path_bad = 1'b1;
          dot_run = 2'd0;
        end else if (b == CharDot) begin
          if (dot_run != 2'd3) dot_run++;
        end else begin
          dot_run = 2'd3;
        end
        field_cnt++;
        fin = (field_cnt >= {16'h0, name_len});
        push_word(KindPath, b, StOk, fin);
        if (fin) begin
          if (dot_run == 2'd2) path_bad = 1'b1;
          lang_ok = (lang_sel == LangZero && lang0_on) || (lang_sel == LangOne && lang1_on);
          if (path_bad || !lang_ok) begin
            rehunt();
            push_word(KindReply, 8'h00, path_bad ? StBadPath : StBadLang, 1'b0);
          end else begin
            field_cnt = 32'h0;
            body_len  = 32'h0;
            ph = PhDlen;
          end
        end
      end
      PhDlen: begin
        body_len[{field_cnt[1:0], 3'b000} +: 8] = b;
        field_cnt++;
        if (field_cnt == 32'd4) begin
          if (body_len > payload_cap) begin
            rehunt();
            push_word(KindReply, 8'h00, StTooLarge, 1'b0);
          end else begin
            crc_acc   = CrcInit;
            crc_rx    = 32'h0;
            field_cnt = 32'h0;
            ph = (body_len == 32'h0) ? PhCrc : PhData;
          end
        end
      end
      PhData: begin
        crc_acc = crc_fold(crc_acc, b);
        field_cnt++;
        fin = (field_cnt >= body_len);
        push_word(KindData, b, StOk, fin);
        if (fin) begin
          field_cnt = 32'h0;
          ph = PhCrc;
        end
      end
      PhCrc: begin
        crc_rx[{field_cnt[1:0], 3'b000} +: 8] = b;
        field_cnt++;
        if (field_cnt == 32'd4) begin
          rehunt();
          push_word(KindReply, 8'h00, ((~crc_acc) == crc_rx) ? StOk : StCrcMismatch, 1'b0);
        end
      end
      default: rehunt();
    endcase
  endfunction

  // Link byte driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
    end else begin
      if (s_axis_tvalid && s_axis_tready) take_byte(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (link_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= link_bytes.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Register write driver
  always @(posedge clk_i) begin : cfg_drive
    reg_write_t w;
    if (!rst_ni) begin
      cfg_valid_i <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) apply_reg(cfg_index_i, cfg_data_i);
      if (!cfg_valid_i || cfg_ready_o) begin
        if (cfg_writes.size() != 0) begin
          w = cfg_writes.pop_front();
          cfg_valid_i <= 1'b1;
          cfg_index_i <= w.idx;
          cfg_data_i  <= w.val;
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output word checker
  always @(posedge clk_i) begin : word_check
    fur_result_t got;
    fur_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind   = fur_kind_e'(m_axis_tuser);
        got.data   = m_axis_tdata[7:0];
        got.status = fur_status_e'(m_axis_tdata[10:8]);
        got.last   = m_axis_tlast;
        if (due_words.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word: expected none, got kind %0d byte %02h status %0d last %0b",
                   $time, got.kind, got.data, got.status, got.last);
        end else begin
          want = due_words.pop_front();
          if (got.kind != want.kind || got.data != want.data ||
              got.status != want.status || got.last != want.last) begin
            fail_count++;
            $display("%0t: word mismatch: expected kind %0d byte %02h status %0d last %0b, %s",
                     $time, want.kind, want.data, want.status, want.last,
                     $sformatf("got kind %0d byte %02h status %0d last %0b",
                               got.kind, got.data, got.status, got.last));
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    link_bytes.push_back(b);
    sent_count++;
  endtask

  task automatic send_head(input logic [7:0] version, input logic [7:0] cmd);
    for (int k = 0; k < 4; k++) send_byte(MagicWord[k]);
    send_byte(version);
    send_byte(cmd);
  endtask

  task automatic load_path(input string s);
    path_buf.delete();
    for (int i = 0; i < s.len(); i++) path_buf.push_back(s[i]);
  endtask

  // Random path of n bytes; a dirty one gets one forbidden feature planted.
  task automatic make_path(input int unsigned n, input bit clean);
    logic [7:0]  c;
    int unsigned r;
    int unsigned k;
    path_buf.delete();
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 60) c = 8'(8'h61 + $urandom_range(25));
      else if (r < 70) c = 8'(8'h30 + $urandom_range(9));
      else if (r < 80) c = CharDot;
      else if (r < 90 && k != 0) c = CharSlash;
      else if (r < 95) c = 8'h5F;
      else c = 8'(8'h80 + $urandom_range(127));
      path_buf.push_back(c);
    end
    if (!clean) begin
      k = $urandom_range(n - 1);
      case ($urandom_range(4))
        0: path_buf[0] = CharSlash;
        1: path_buf[k] = CharBackslash;
        2: path_buf[k] = CharColon;
        3: path_buf[k] = 8'($urandom_range(31));
        default: begin
          if (n >= 2) begin
            path_buf[0] = CharDot;
            path_buf[1] = CharDot;
            if (n >= 3) path_buf[2] = CharSlash;
          end else begin
            path_buf[0] = CharColon;
          end
        end
      endcase
    end
  endtask

  // Upload frame; the path comes from path_buf, the payload is random.
  task automatic send_put(input logic [7:0] lang, input logic [15:0] plen,
                          input logic [31:0] dlen, input int unsigned ndata,
                          input bit crc_good);
    logic [31:0] crc;
    logic [7:0]  d;
    crc = CrcInit;
    send_head(VersionOne, CmdPut);
    send_byte(lang);
    send_byte(plen[7:0]);
    send_byte(plen[15:8]);
    if (plen == 16'h0 || plen >= PathLimit) return;
    foreach (path_buf[i]) send_byte(path_buf[i]);
    for (int k = 0; k < 4; k++) send_byte(dlen[8*k +: 8]);
    for (int k = 0; k < ndata; k++) begin
      d = 8'($urandom_range(255));
      crc = crc_fold(crc, d);
      send_byte(d);
    end
    crc = ~crc;
    if (!crc_good) crc ^= 32'h1 << $urandom_range(31);
    for (int k = 0; k < 4; k++) send_byte(crc[8*k +: 8]);
  endtask

  task automatic random_frame();
    int unsigned pick;
    int unsigned n;
    int unsigned ndata;
    logic [7:0]  lang;
    logic [15:0] plen;
    logic [31:0] dlen;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_head(VersionOne, CmdPing);
    end else if (pick < 13) begin
      send_head(8'(8'h02 + $urandom_range(253)), 8'($urandom_range(255)));
    end else if (pick < 17) begin
      send_head(VersionOne, 8'(8'h03 + $urandom_range(252)));
    end else if (pick < 25) begin
      // line noise, often a torn sync pattern
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++)
        send_byte($urandom_range(1) ? MagicWord[k % 4] : 8'($urandom_range(255)));
    end else begin
      if ($urandom_range(99) < 88) begin
        if (lang0_on && lang1_on) lang = $urandom_range(1) ? LangOne : LangZero;
        else if (lang0_on) lang = LangZero;
        else if (lang1_on) lang = LangOne;
        else lang = $urandom_range(1) ? LangOne : LangZero;
      end else begin
        lang = 8'($urandom_range(255));
      end
      pick = $urandom_range(99);
      if (pick < 4) n = $urandom_range(200, PathLimit - 1);
      else if (pick < 92) n = $urandom_range(1, 16);
      else n = 0;
      if (n != 0) begin
        plen = 16'(n);
        make_path(n, $urandom_range(99) < 88);
      end else begin
        plen = $urandom_range(1) ? 16'h0 : 16'($urandom_range(PathLimit, 16'hFFFF));
      end
      if (payload_cap != 32'hFFFF_FFFF && $urandom_range(99) < 10) begin
        dlen  = $urandom_range(1) ? 32'hFFFF_FFFF : payload_cap + 1;
        ndata = 0;
      end else begin
        ndata = $urandom_range(0, (payload_cap < 24) ? payload_cap : 24);
        dlen  = ndata;
      end
      send_put(lang, plen, dlen, ndata, $urandom_range(99) < 85);
    end
  endtask

  // Hold until every queued word has moved and every expected word has arrived.
  task automatic settle();
    do @(negedge clk_i);
    while (link_bytes.size() != 0 || s_axis_tvalid || cfg_writes.size() != 0 ||
           cfg_valid_i || due_words.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic l0, input logic l1, input logic [31:0] cap,
                           input int unsigned gap, input int unsigned stall,
                           input int unsigned budget);
    int unsigned start;
    settle();
    cfg_writes.push_back('{idx: CfgLang0, val: {31'h0, l0}});
    cfg_writes.push_back('{idx: CfgLang1, val: {31'h0, l1}});
    cfg_writes.push_back('{idx: CfgMaxLen, val: cap});
    settle();
    send_gap_pct = gap;
    stall_pct    = stall;
    start = sent_count;
    while (sent_count - start < budget) random_frame();
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed cases under the reset register values
    send_byte(MagicWord[0]);
    send_head(VersionOne, CmdPing);
    send_head(8'hFE, CmdPing);
    send_head(VersionOne, 8'h00);
    send_head(VersionOne, 8'hFF);
    send_put(LangZero, 16'h0, 32'h0, 0, 1'b1);
    send_put(LangZero, PathLimit, 32'h0, 0, 1'b1);
    send_put(LangZero, 16'hFFFF, 32'h0, 0, 1'b1);
    load_path("/a");
    send_put(LangZero, 2, 32'h0, 0, 1'b1);
    load_path("a/../b");
    send_put(LangZero, 6, 32'h0, 0, 1'b1);
    load_path("x/..");
    send_put(LangZero, 4, 32'h0, 0, 1'b1);
    load_path("a:b\\c\t");
    send_put(LangZero, 6, 32'h0, 0, 1'b1);
    load_path("ok.txt");
    send_put(8'hFF, 6, 32'h0, 0, 1'b1);
    send_put(LangOne, 6, 32'h0, 0, 1'b1);
    load_path(".../.a");
    send_put(LangZero, 6, 32'h0, 0, 1'b1);
    load_path("d/f.bin");
    send_put(LangZero, 7, 32'h2, 2, 1'b1);
    send_put(LangZero, 7, 32'h3, 3, 1'b0);
    send_put(LangZero, 7, 32'hFFFF_FFFF, 0, 1'b1);
    load_path("q");
    send_put(LangZero, 1, DefMaxPayload + 1, 0, 1'b1);
    make_path(PathLimit - 1, 1'b1);
    send_put(LangZero, 16'(PathLimit - 1), 32'h1, 1, 1'b1);

    run_phase(1'b0, 1'b1, 32'd24, 45, 0, 180);
    run_phase(1'b1, 1'b1, 32'hFFFF_FFFF, 0, 45, 180);
    run_phase(1'b0, 1'b0, 32'h0, 9, 9, 60);
    settle();
    cfg_writes.push_back('{idx: CfgUnused, val: 32'hFFFF_FFFF});
    run_phase(1'b1, 1'b0, 32'd5, 9, 9, 150);
    run_phase(1'b1, 1'b1, 32'd20, 0, 0, 150);

    settle();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
